// ----- src/rmcs_pkg.sv -----
package rmcs_pkg;

  // Message buffer depth, 1 to 255 entries.
  localparam int unsigned MsgDepth = 128;
  localparam int unsigned MsgAddrW = (MsgDepth > 1) ? $clog2(MsgDepth) : 1;

  localparam logic [3:0] ColumnsPerCharReset = 4'd5;
  localparam logic [7:0] EndByteReset        = 8'd13;

  typedef enum logic [1:0] {
    ActRxByte = 2'd0,
    ActHome   = 2'd1,
    ActTick   = 2'd2
  } action_e;

  typedef enum logic {
    CfgColumnsPerChar = 1'b0,
    CfgEndByte        = 1'b1
  } cfg_index_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] rx_byte;
  } cmd_t;

  typedef struct packed {
    logic       blank;
    logic [7:0] char_code;
    logic [3:0] column;
  } result_t;

endpackage

// ----- src/rotating_message_column_sequencer_top.sv -----
// Column sequencer for a rotating message display.
//
// Command channel: an item (action and rx_byte) is accepted at a rising edge
// where start_i is high and busy_o is low. busy_o stays low, so one item can
// be accepted in every cycle. A received byte appends to the message buffer,
// a home pulse restarts playback and an angle tick asks for the next column.
// Only an angle tick gives a result: it appears on result_o with
// result_valid_o high for exactly one cycle, the cycle after the tick was
// accepted; a tick in playback that finds no column to show gives none. The
// delay is the registered read of the synchronous message buffer at the
// playback position. Other state is updated at the accepting edge, so the
// next item may follow at once. The receiver cannot stall, and none is needed.
//
// Configuration: cfg_valid_i, cfg_index_i and cfg_data_i write the columns per
// character (index 0, low four bits) or the end byte (index 1). cfg_ready_o is
// always high. The user makes writes while no tick is in flight, unchecked.
//
// Reset clears the count, position and flags and loads the register reset
// values. The buffer contents are not cleared; only written entries are read.
module rotating_message_column_sequencer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rmcs_pkg::cmd_t      cmd_i,
  output logic                busy_o,
  output logic                result_valid_o,
  output rmcs_pkg::result_t   result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  rmcs_pkg::cfg_index_e cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import rmcs_pkg::*;

  logic [7:0] msg_mem [MsgDepth];
  logic [7:0] rdata_q;

  logic [3:0] cpc_q, cpc_d;
  logic [7:0] end_byte_q, end_byte_d;
  logic [7:0] msg_count_q, msg_count_d;
  logic [7:0] char_pos_q, char_pos_d;
  logic [3:0] col_pos_q, col_pos_d;
  logic       playing_q, playing_d;
  logic       pending_q, pending_d;
  logic       strobe_q, strobe_d;
  logic       blank_q, blank_d;
  logic [3:0] column_q, column_d;

  logic       accept;
  logic       cfg_we;
  logic       mem_we, mem_re;
  logic [7:0] base_count;
  logic [3:0] col_inc;
  logic [7:0] char_inc;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cpc_d      = cpc_q;
    end_byte_d = end_byte_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CfgColumnsPerChar: cpc_d      = cfg_data_i[3:0];
        CfgEndByte:        end_byte_d = cfg_data_i;
        default:           ;
      endcase
    end
  end

  always_comb begin
    msg_count_d = msg_count_q;
    char_pos_d  = char_pos_q;
    col_pos_d   = col_pos_q;
    playing_d   = playing_q;
    pending_d   = pending_q;
    strobe_d    = 1'b0;
    blank_d     = blank_q;
    column_d    = column_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    base_count  = pending_q ? 8'd0 : msg_count_q;
    col_inc     = col_pos_q + 4'd1;
    char_inc    = char_pos_q + 8'd1;

    if (accept) begin
      case (cmd_i.action)
        ActRxByte: begin
          playing_d = 1'b0;
          if (cmd_i.rx_byte != end_byte_q && base_count < 8'(MsgDepth)) begin
            mem_we      = 1'b1;
            msg_count_d = base_count + 8'd1;
            pending_d   = 1'b0;
          end else begin
            msg_count_d = base_count;
            pending_d   = 1'b1;
          end
        end
        ActHome: begin
          char_pos_d = 8'd0;
          col_pos_d  = 4'd0;
          playing_d  = 1'b1;
        end
        ActTick: begin
          if (!playing_q) begin
            strobe_d = 1'b1;
            blank_d  = 1'b1;
            column_d = 4'd0;
          end else begin
            if (col_pos_q < cpc_q && char_pos_q < msg_count_q) begin
              strobe_d = 1'b1;
              blank_d  = 1'b0;
              column_d = col_pos_q;
              mem_re   = 1'b1;
            end
            // The column wraps on reaching the width, or on four-bit overflow.
            col_pos_d = col_inc;
            if (col_inc >= cpc_q || col_inc == 4'd0) begin
              col_pos_d  = 4'd0;
              char_pos_d = char_inc;
            end
            if (char_pos_d >= msg_count_q) begin
              playing_d = 1'b0;
              col_pos_d = 4'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Message buffer: one write port at the count, one read port at the position.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      msg_mem[base_count[MsgAddrW-1:0]] <= cmd_i.rx_byte;
    end
    if (mem_re) begin
      rdata_q <= msg_mem[char_pos_q[MsgAddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpc_q       <= ColumnsPerCharReset;
      end_byte_q  <= EndByteReset;
      msg_count_q <= 8'd0;
      char_pos_q  <= 8'd0;
      col_pos_q   <= 4'd0;
      playing_q   <= 1'b0;
      pending_q   <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      cpc_q       <= cpc_d;
      end_byte_q  <= end_byte_d;
      msg_count_q <= msg_count_d;
      char_pos_q  <= char_pos_d;
      col_pos_q   <= col_pos_d;
      playing_q   <= playing_d;
      pending_q   <= pending_d;
      strobe_q    <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blank_q  <= blank_d;
    column_q <= column_d;
  end

  assign result_valid_o     = strobe_q;
  assign result_o.blank     = blank_q;
  assign result_o.char_code = blank_q ? 8'd0 : rdata_q;
  assign result_o.column    = column_q;

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept && cmd_i.action == ActTick))
    else $error("result item without an accepted tick");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_count_q <= 8'(MsgDepth))
    else $error("message count beyond buffer depth");

  a_new_message_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.action == ActRxByte && pending_q && cmd_i.rx_byte != end_byte_q)
      |=> (msg_count_q == 8'd1 && !pending_q))
    else $error("first byte of a new message not stored at entry zero");

  a_shown_tick_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.blank) |-> $past(mem_re && !mem_we))
    else $error("shown column without a buffer read");

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import rmcs_pkg::*;

  // Action code that the block does not use.
  localparam action_e ActUnused = action_e'(2'd3);

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned SettleCycles  = 2;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned TickCap       = 60;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  cmd_t       cmd_i;
  logic       busy_o;
  logic       result_valid_o;
  result_t    result_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  cfg_index_e cfg_index_i;
  logic [7:0] cfg_data_i;

  rotating_message_column_sequencer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the sequencer state and its registers.
  logic [7:0] msg_mem [MsgDepth];
  logic [7:0] msg_len;
  logic [7:0] pos_char;
  logic [3:0] pos_col;
  logic       is_playing;
  logic       new_pending;
  logic [3:0] cols_per_char;
  logic [7:0] end_code;

  result_t     expected_columns [$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned idle_pct;
  int unsigned stall_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic predict_column(input cmd_t c);
    result_t    r;
    logic [3:0] next_col;
    case (c.action)
      ActRxByte: begin
        is_playing = 1'b0;
        if (new_pending) begin
          msg_len     = '0;
          new_pending = 1'b0;
        end
        if (c.rx_byte != end_code && msg_len < MsgDepth) begin
          msg_mem[msg_len[MsgAddrW-1:0]] = c.rx_byte;
          msg_len                        = msg_len + 8'd1;
        end else begin
          new_pending = 1'b1;
        end
      end
      ActHome: begin
        pos_char   = '0;
        pos_col    = '0;
        is_playing = 1'b1;
      end
      ActTick: begin
        if (!is_playing) begin
          r.blank     = 1'b1;
          r.char_code = '0;
          r.column    = '0;
          expected_columns.push_back(r);
        end else begin
          if (pos_col < cols_per_char && pos_char < msg_len) begin
            r.blank     = 1'b0;
            r.char_code = msg_mem[pos_char[MsgAddrW-1:0]];
            r.column    = pos_col;
            expected_columns.push_back(r);
          end
          // A column index that has run past the width also moves on to
          // the next character.
          next_col = pos_col + 4'd1;
          if (next_col >= cols_per_char || next_col == 4'd0) begin
            pos_col  = '0;
            pos_char = pos_char + 8'd1;
          end else begin
            pos_col = next_col;
          end
          if (pos_char >= msg_len) begin
            is_playing = 1'b0;
            pos_col    = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%s", msg);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_columns.size() == 0) begin
        note_failure($sformatf("Unexpected column result: blank=%0d code=%02h col=%0d",
                               result_o.blank, result_o.char_code, result_o.column));
      end else begin
        want = expected_columns.pop_front();
        if (result_o.blank !== want.blank || result_o.char_code !== want.char_code ||
            result_o.column !== want.column) begin
          note_failure($sformatf(
            "Column result wrong: expected blank=%0d code=%02h col=%0d, got blank=%0d code=%02h col=%0d",
            want.blank, want.char_code, want.column,
            result_o.blank, result_o.char_code, result_o.column));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input action_e act, input logic [7:0] b);
    cmd_t c;
    c.action  = act;
    c.rx_byte = b;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_column(c);
    if (act != ActUnused) begin
      items_sent++;
    end
  endtask

  // Holds the sender back until every expected column has come out.
  task automatic settle();
    start_i <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgColumnsPerChar: cols_per_char = data[3:0];
      CfgEndByte:        end_code      = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [3:0] cols, input logic [7:0] term);
    settle();
    write_reg(CfgColumnsPerChar, {4'h0, cols});
    write_reg(CfgEndByte, term);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == end_code) begin
      b = b ^ 8'h01;
    end
    return b;
  endfunction

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(ActTick, 8'($urandom));
  endtask

  // Types a message, optionally terminates it, and plays it back with a
  // little noise mixed in.
  task automatic play_message(input int unsigned len, input bit terminate);
    int unsigned n;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_item(ActRxByte, end_code);
      end else begin
        send_item(ActRxByte, plain_byte());
      end
    end
    if (terminate) begin
      send_item(ActRxByte, end_code);
    end
    send_item(ActHome, 8'($urandom));
    n = len * cols_per_char + $urandom_range(0, 4);
    if (n > TickCap) begin
      n = TickCap;
    end
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_item(action_e'(2'($urandom_range(0, 3))), 8'($urandom));
      end
      send_item(ActTick, 8'($urandom));
    end
  endtask

  task automatic test_stopped_and_empty();
    send_ticks(1);
    send_item(ActUnused, 8'hFF);
    send_item(ActHome, 8'h00);
    send_ticks(2);
  endtask

  task automatic test_field_extremes();
    send_item(ActRxByte, 8'h00);
    send_item(ActRxByte, 8'hFF);
    send_item(ActRxByte, end_code);
    send_item(ActHome, 8'hFF);
    send_ticks(11);
    // A byte arriving during playback stops it and starts a new message.
    send_item(ActHome, 8'h00);
    send_ticks(2);
    send_item(ActRxByte, 8'h80);
    send_ticks(1);
  endtask

  task automatic test_column_past_width();
    set_registers(4'd15, end_code);
    send_item(ActRxByte, 8'h41);
    send_item(ActRxByte, 8'h42);
    send_item(ActRxByte, 8'h43);
    send_item(ActRxByte, end_code);
    send_item(ActHome, 8'h00);
    send_ticks(9);
    settle();
    write_reg(CfgColumnsPerChar, 8'd3);
    send_ticks(8);
  endtask

  task automatic test_buffer_full();
    settle();
    write_reg(CfgColumnsPerChar, 8'd1);
    send_item(ActRxByte, end_code);
    for (int unsigned i = 0; i < MsgDepth + 1; i++) begin
      send_item(ActRxByte, plain_byte());
    end
    send_item(ActHome, 8'h00);
    send_ticks(10);
    send_item(ActRxByte, plain_byte());
    send_item(ActHome, 8'h00);
    send_ticks(3);
  endtask

  task automatic test_register_extremes();
    logic [3:0] cols [4] = '{4'd1, 4'd15, 4'd1, 4'd15};
    logic [7:0] terms [4] = '{8'h00, 8'hFF, 8'hFF, 8'h00};
    for (int k = 0; k < 4; k++) begin
      set_registers(cols[k], terms[k]);
      repeat (3) play_message($urandom_range(1, 6), 1'b1);
    end
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned count);
    int unsigned target;
    int unsigned msgs;
    idle_pct = pct;
    target   = items_sent + count;
    msgs     = 0;
    while (items_sent < target) begin
      // Registers change now and then, often with playback still under way.
      if (msgs % 8 == 0) begin
        set_registers(4'($urandom_range(1, 15)), 8'($urandom));
      end
      if ($urandom_range(0, 11) == 0) begin
        play_message($urandom_range(110, 140), $urandom_range(0, 4) != 0);
      end else begin
        play_message($urandom_range(1, 12), $urandom_range(0, 4) != 0);
      end
      msgs++;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    cmd_i         = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgColumnsPerChar;
    cfg_data_i    = '0;
    msg_len       = '0;
    pos_char      = '0;
    pos_col       = '0;
    is_playing    = 1'b0;
    new_pending   = 1'b0;
    cols_per_char = ColumnsPerCharReset;
    end_code      = EndByteReset;
    fail_count    = 0;
    items_sent    = 0;
    idle_pct      = 34;
    stall_cycles  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stopped_and_empty();
    test_field_extremes();
    test_column_past_width();
    test_buffer_full();
    test_register_extremes();
    test_random_traffic(34, 400);
    test_random_traffic(85, 350);
    test_random_traffic(0, 400);

    settle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && expected_columns.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/rmcs_pkg.sv
src/rotating_message_column_sequencer_top.sv
bench/testbench.sv
